FILE: rtl/core/mtt_pkg.sv
`timescale 1ns / 1ps
package mtt_pkg;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [1:0]         det_count;
    logic [7:0]         det0_id;
    logic signed [15:0] det0_x;
    logic signed [15:0] det0_y;
    logic [7:0]         det1_id;
    logic signed [15:0] det1_x;
    logic signed [15:0] det1_y;
    logic [7:0]         det2_id;
    logic signed [15:0] det2_x;
    logic signed [15:0] det2_y;
  } mtt_in_t;

  typedef struct packed {
    logic [1:0]         track_slot;
    logic [7:0]         track_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         age_class;
    logic               last_of_frame;
  } mtt_out_t;

  typedef struct packed {
    logic [15:0] stale_timeout_ms;
    logic [9:0]  render_lag_ms;
    logic [15:0] fresh_age_ms;
    logic [15:0] recent_age_ms;
  } mtt_cfg_t;

  localparam logic [1:0] REG_STALE  = 2'd0;
  localparam logic [1:0] REG_DELAY  = 2'd1;
  localparam logic [1:0] REG_FRESH  = 2'd2;
  localparam logic [1:0] REG_RECENT = 2'd3;

  localparam logic [1:0] CLS_FRESH  = 2'd0;
  localparam logic [1:0] CLS_RECENT = 2'd1;
  localparam logic [1:0] CLS_OLD    = 2'd2;

endpackage

FILE: rtl/core/multi_target_track_table.sv
`timescale 1ns / 1ps
// Multi-target track table.
// The input channel (in_valid/in_ready/in_data) carries one sensor frame per
// transfer: a time stamp and up to three detections. For each frame the
// block drops tracks whose age reached the stale timeout, applies the
// detections in order, and then returns one result transfer per live track
// on the out channel, in slot order, with last_of_frame set on the final one.
// An empty table gives no result transfer for that frame.
// A frame passes through a drop scan over the tracks held before it, a step
// for each detection, and then an emit and an output step for each result;
// an interpolated result also runs the bit-serial divider for x, then for y.
// The next frame starts once the last result of the current one is taken.
// A two-entry frame queue lets new frames be accepted while results wait.
// When the receiver stalls, the result register holds and the sequencer
// waits; once the queue is full, in_ready drops.
// The user must write configuration over the APB-style cfg_ port only while
// idle; the block does not enforce this. Reset (rst_n low, synchronous)
// empties the table and the queue and loads the default thresholds.
module multi_target_track_table import mtt_pkg::*; #(
  parameter int TRACK_SLOTS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mtt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mtt_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  mtt_cfg_t cfg_r;
  logic     q_valid, q_pop;
  mtt_in_t  q_data;
  logic [1:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_timeout_ms <= 16'd1000;
      cfg_r.render_lag_ms    <= 10'd50;
      cfg_r.fresh_age_ms     <= 16'd200;
      cfg_r.recent_age_ms    <= 16'd500;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_STALE:  cfg_r.stale_timeout_ms <= cfg_pwdata[15:0];
        REG_DELAY:  cfg_r.render_lag_ms    <= cfg_pwdata[9:0];
        REG_FRESH:  cfg_r.fresh_age_ms     <= cfg_pwdata[15:0];
        default:    cfg_r.recent_age_ms    <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_STALE: cfg_prdata = {16'd0, cfg_r.stale_timeout_ms};
      REG_DELAY: cfg_prdata = {22'd0, cfg_r.render_lag_ms};
      REG_FRESH: cfg_prdata = {16'd0, cfg_r.fresh_age_ms};
      default:   cfg_prdata = {16'd0, cfg_r.recent_age_ms};
    endcase
  end

  mtt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  mtt_back #(.TRACK_SLOTS(TRACK_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );
endmodule

FILE: rtl/core/mtt_front.sv
`timescale 1ns / 1ps
// Input frame queue: a two-entry FIFO of accepted frames.
module mtt_front import mtt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  mtt_in_t in_data,
  output logic    q_valid,
  input  logic    q_pop,
  output mtt_in_t q_data
);
  mtt_in_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: rtl/core/mtt_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, signed numerator truncating to zero.
module mtt_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [48:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [48:0] quot
);
  logic [48:0] q_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r, busy_r, done_r;
  logic [32:0] trial;
  logic [31:0] den_r;

  assign trial = {rem_r[31:0], q_r[48]} - {1'b0, den_r};
  assign done  = done_r;
  assign quot  = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[48] ? 49'(-num) : num;
      neg_r <= num[48];
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r   <= {q_r[47:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[48]};
        q_r   <= {q_r[47:0], 1'b0};
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; cnt_r <= 6'd48;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/core/mtt_back.sv
`timescale 1ns / 1ps
// Track table sequencer: drop stale, apply detections, then emit one result per live track.
module mtt_back import mtt_pkg::*; #(
  parameter int TRACK_SLOTS = 3
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mtt_cfg_t cfg,
  input  logic     q_valid,
  output logic     q_pop,
  input  mtt_in_t  q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mtt_out_t out_data
);
  localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CW = $clog2(TRACK_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DROP  = 7'b0000010,
    S_DET   = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_DIVX  = 7'b0010000,
    S_DIVY  = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t st_r;
  logic [7:0]         id_r [TRACK_SLOTS];
  logic signed [15:0] cx_r [TRACK_SLOTS], cy_r [TRACK_SLOTS];
  logic signed [15:0] px_r [TRACK_SLOTS], py_r [TRACK_SLOTS];
  logic [31:0]        seen_r [TRACK_SLOTS], ptime_r [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] hist_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      i_r;
  logic [1:0]         k_r;
  mtt_out_t           res_r;
  logic               res_v_r;

  logic [SW-1:0] is;
  logic [31:0]   now, age, render, span, el;
  logic [7:0]    did;
  logic signed [15:0] dx, dy;
  logic          found;
  logic [SW-1:0] fslot, eslot, tslot;
  logic          dstart;
  logic signed [48:0] dnum;
  logic          ddone;
  logic signed [48:0] dq;
  logic          interp, useprev;
  logic [1:0]    cls;

  assign now    = q_data.now_ms;
  assign is     = i_r[SW-1:0];
  assign age    = now - seen_r[is];
  assign render = (now > {22'd0, cfg.render_lag_ms}) ?
                  now - {22'd0, cfg.render_lag_ms} : 32'd0;
  assign span   = seen_r[is] - ptime_r[is];
  assign el     = render - ptime_r[is];

  always_comb begin
    case (k_r)
      2'd0:    begin did = q_data.det0_id; dx = q_data.det0_x; dy = q_data.det0_y; end
      2'd1:    begin did = q_data.det1_id; dx = q_data.det1_x; dy = q_data.det1_y; end
      default: begin did = q_data.det2_id; dx = q_data.det2_x; dy = q_data.det2_y; end
    endcase
  end

  // Matching and eviction scan the small slot file in one pass.
  always_comb begin
    found = 1'b0; fslot = '0; eslot = '0;
    for (int j = TRACK_SLOTS - 1; j >= 0; j--) begin
      if (CW'(j) < cnt_r && id_r[j] == did) begin
        found = 1'b1; fslot = SW'(j);
      end
    end
    for (int j = 1; j < TRACK_SLOTS; j++) begin
      if (seen_r[j] < seen_r[eslot]) eslot = SW'(j);
    end
    if (found) tslot = fslot;
    else if (cnt_r < CW'(TRACK_SLOTS)) tslot = cnt_r[SW-1:0];
    else tslot = eslot;
  end

  always_comb begin
    interp  = !(!hist_r[is] || seen_r[is] <= ptime_r[is] || render >= seen_r[is]);
    useprev = interp && (render <= ptime_r[is]);
    if (age < {16'd0, cfg.fresh_age_ms}) cls = CLS_FRESH;
    else if (age < {16'd0, cfg.recent_age_ms}) cls = CLS_RECENT;
    else cls = CLS_OLD;
  end

  // A new result is only built once the previous one has been taken.
  assign dstart = (st_r == S_EMIT && !res_v_r && interp && !useprev) ||
                  (st_r == S_DIVX && ddone);
  assign dnum = (st_r == S_EMIT) ?
                49'(($signed({cx_r[is][15], cx_r[is]}) - $signed({px_r[is][15], px_r[is]}))
                    * $signed({1'b0, el})) :
                49'(($signed({cy_r[is][15], cy_r[is]}) - $signed({py_r[is][15], py_r[is]}))
                    * $signed({1'b0, el}));

  mtt_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(span),
    .done(ddone), .quot(dq)
  );

  assign q_pop     = (st_r == S_OUT) && !res_v_r && (i_r == cnt_r);
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; hist_r <= '0; res_v_r <= 1'b0;
      i_r <= '0; k_r <= '0;
    end else begin
      if (res_v_r && out_ready) res_v_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin st_r <= S_DROP; i_r <= '0; end
        S_DROP: begin
          if (i_r >= cnt_r) begin
            st_r <= S_DET; k_r <= '0;
          end else if (age >= {16'd0, cfg.stale_timeout_ms}) begin
            for (int j = 0; j < TRACK_SLOTS - 1; j++) begin
              if (CW'(j) >= i_r) begin
                id_r[j] <= id_r[j+1]; cx_r[j] <= cx_r[j+1]; cy_r[j] <= cy_r[j+1];
                px_r[j] <= px_r[j+1]; py_r[j] <= py_r[j+1];
                seen_r[j] <= seen_r[j+1]; ptime_r[j] <= ptime_r[j+1];
                hist_r[j] <= hist_r[j+1];
              end
            end
            cnt_r <= cnt_r - CW'(1);
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_DET: begin
          if ({1'b0, k_r} >= {1'b0, q_data.det_count}) begin
            st_r <= S_EMIT; i_r <= '0;
            if (cnt_r == '0) st_r <= S_OUT;
          end else begin
            if (found) begin
              px_r[tslot] <= cx_r[tslot]; py_r[tslot] <= cy_r[tslot];
              ptime_r[tslot] <= seen_r[tslot]; hist_r[tslot] <= 1'b1;
            end else begin
              px_r[tslot] <= dx; py_r[tslot] <= dy;
              ptime_r[tslot] <= now; hist_r[tslot] <= 1'b0;
              if (cnt_r < CW'(TRACK_SLOTS)) cnt_r <= cnt_r + CW'(1);
            end
            id_r[tslot] <= did; cx_r[tslot] <= dx; cy_r[tslot] <= dy;
            seen_r[tslot] <= now;
            k_r <= k_r + 2'd1;
          end
        end
        S_EMIT: if (!res_v_r) begin
          res_r.track_slot    <= 2'(i_r);
          res_r.track_id      <= id_r[is];
          res_r.age_class     <= cls;
          res_r.last_of_frame <= (i_r + CW'(1) == cnt_r);
          res_r.pos_x <= useprev ? px_r[is] : cx_r[is];
          res_r.pos_y <= useprev ? py_r[is] : cy_r[is];
          st_r <= (interp && !useprev) ? S_DIVX : S_OUT;
        end
        S_DIVX: if (ddone) begin
          res_r.pos_x <= 16'(px_r[is] + 16'(dq));
          st_r <= S_DIVY;
        end
        S_DIVY: if (ddone) begin
          res_r.pos_y <= 16'(py_r[is] + 16'(dq));
          st_r <= S_OUT;
        end
        S_OUT: if (!res_v_r) begin
          if (i_r == cnt_r) begin
            st_r <= S_IDLE;
          end else begin
            res_v_r <= 1'b1;
            i_r <= i_r + CW'(1);
            st_r <= (i_r + CW'(1) == cnt_r) ? S_OUT : S_EMIT;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/mtt_checker.sv
`timescale 1ns / 1ps
module mtt_checker import mtt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input mtt_out_t out_data,
  input logic     cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.age_class != 2'd3)
    else $error("bad age class");
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_frame |=>
      !out_valid || out_data.track_slot != 2'd0)
    else $error("frame ended without last flag");
  a_rdy: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind multi_target_track_table mtt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data), .cfg_pready(cfg_pready)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import mtt_pkg::*;

  localparam int SLOTS      = 3;
  localparam int SETTLE_CYC = 1000;  // Covers a frame with three interpolated tracks.

  // One table entry as the bench tracks it.
  typedef struct {
    logic [7:0]         id;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [31:0]        seen;
    logic [31:0]        prev;
    bit                 hist;
  } track_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  mtt_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  mtt_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  multi_target_track_table #(.TRACK_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Frames waiting to be driven, and the track results the table should return.
  mtt_in_t  frame_q[$];
  mtt_out_t track_res_q[$];

  // The bench's own copy of the thresholds and of the track table.
  mtt_cfg_t   thr;
  track_t     trk[SLOTS];
  int         trk_cnt;

  int         errors;
  bit         no_idle;   // When set, neither side inserts gaps.
  logic [31:0] t_now;    // Time stamp of the next generated frame.

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Linear interpolation with a signed 64-bit product and a division that
  // truncates toward zero, then cut back to the 16-bit result field.
  function automatic logic signed [15:0] interp_pos(input logic signed [15:0] a,
                                                    input logic signed [15:0] b,
                                                    input logic [31:0] el,
                                                    input logic [31:0] span);
    longint d;
    longint q;
    d = longint'(b) - longint'(a);
    q = longint'(a) + (d * longint'({32'd0, el})) / longint'({32'd0, span});
    return q[15:0];
  endfunction

  // Runs one frame through the bench's table and queues the results it gives.
  task automatic predict_tracks(input mtt_in_t f);
    logic [31:0]        now;
    logic [31:0]        render;
    logic [31:0]        age;
    logic [7:0]         did[3];
    logic signed [15:0] dx[3];
    logic signed [15:0] dy[3];
    int                 i;
    int                 j;
    int                 slot;
    bit                 found;
    mtt_out_t           r;
    now = f.now_ms;
    did[0] = f.det0_id; dx[0] = f.det0_x; dy[0] = f.det0_y;
    did[1] = f.det1_id; dx[1] = f.det1_x; dy[1] = f.det1_y;
    did[2] = f.det2_id; dx[2] = f.det2_x; dy[2] = f.det2_y;

    // Stale tracks leave first and the rest close up in order.
    i = 0;
    while (i < trk_cnt) begin
      age = now - trk[i].seen;
      if (age >= {16'd0, thr.stale_timeout_ms}) begin
        for (j = i; j + 1 < trk_cnt; j++) trk[j] = trk[j + 1];
        trk_cnt--;
      end else begin
        i++;
      end
    end

    for (int k = 0; k < int'(f.det_count); k++) begin
      found = 0;
      slot = 0;
      for (j = 0; j < trk_cnt; j++) begin
        if (!found && trk[j].id == did[k]) begin
          slot = j;
          found = 1;
        end
      end
      if (found) begin
        trk[slot].px   = trk[slot].cx;
        trk[slot].py   = trk[slot].cy;
        trk[slot].prev = trk[slot].seen;
        trk[slot].hist = 1;
      end else begin
        if (trk_cnt < SLOTS) begin
          slot = trk_cnt;
          trk_cnt++;
        end else begin
          // The oldest track goes; on a tie the lowest slot.
          slot = 0;
          for (j = 1; j < trk_cnt; j++)
            if (trk[j].seen < trk[slot].seen) slot = j;
        end
        trk[slot].px   = dx[k];
        trk[slot].py   = dy[k];
        trk[slot].prev = now;
        trk[slot].hist = 0;
      end
      trk[slot].id   = did[k];
      trk[slot].cx   = dx[k];
      trk[slot].cy   = dy[k];
      trk[slot].seen = now;
    end

    render = (now > {22'd0, thr.render_lag_ms}) ? now - {22'd0, thr.render_lag_ms}
                                                 : 32'd0;
    for (i = 0; i < trk_cnt; i++) begin
      age = now - trk[i].seen;
      r.track_slot = i[1:0];
      r.track_id   = trk[i].id;
      if (!trk[i].hist || trk[i].seen <= trk[i].prev || render >= trk[i].seen) begin
        r.pos_x = trk[i].cx;
        r.pos_y = trk[i].cy;
      end else if (render <= trk[i].prev) begin
        r.pos_x = trk[i].px;
        r.pos_y = trk[i].py;
      end else begin
        r.pos_x = interp_pos(trk[i].px, trk[i].cx, render - trk[i].prev,
                             trk[i].seen - trk[i].prev);
        r.pos_y = interp_pos(trk[i].py, trk[i].cy, render - trk[i].prev,
                             trk[i].seen - trk[i].prev);
      end
      if (age < {16'd0, thr.fresh_age_ms}) r.age_class = CLS_FRESH;
      else if (age < {16'd0, thr.recent_age_ms}) r.age_class = CLS_RECENT;
      else r.age_class = CLS_OLD;
      r.last_of_frame = (i + 1 == trk_cnt);
      track_res_q.push_back(r);
    end
  endtask

  // Input driver. A transfer takes place when valid and ready are both high
  // at the edge; the frame is handed to the predictor at that moment. A new
  // frame is only presented once the slot is free, so valid stays high with
  // a stable payload until its transfer, and is never dropped and raised in
  // the same step.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_tracks(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          in_data  <= frame_q.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Every result transfer is checked field by field against
  // the oldest expected result; out_ready stalls at random.
  int out_gap;
  always @(posedge clk) begin
    mtt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (track_res_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 32'd0);
        end else begin
          want = track_res_q.pop_front();
          if (out_data.track_slot != want.track_slot)
            report_mismatch("track_slot", 32'(out_data.track_slot), 32'(want.track_slot));
          if (out_data.track_id != want.track_id)
            report_mismatch("track_id", 32'(out_data.track_id), 32'(want.track_id));
          if (out_data.pos_x != want.pos_x)
            report_mismatch("pos_x", 32'(out_data.pos_x), 32'(want.pos_x));
          if (out_data.pos_y != want.pos_y)
            report_mismatch("pos_y", 32'(out_data.pos_y), 32'(want.pos_y));
          if (out_data.age_class != want.age_class)
            report_mismatch("age_class", 32'(out_data.age_class), 32'(want.age_class));
          if (out_data.last_of_frame != want.last_of_frame)
            report_mismatch("last_of_frame", 32'(out_data.last_of_frame),
                            32'(want.last_of_frame));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // One APB write, setup then access, followed by a read back of the same
  // register. The register takes the value at the end of the access cycle.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_DELAY) ? 32'h3FF : 32'hFFFF;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_STALE:  thr.stale_timeout_ms = val[15:0];
      REG_DELAY:  thr.render_lag_ms    = val[9:0];
      REG_FRESH:  thr.fresh_age_ms     = val[15:0];
      default:    thr.recent_age_ms    = val[15:0];
    endcase
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata != (val & mask)) report_mismatch("register read", cfg_prdata, val & mask);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [15:0] stale, input logic [9:0] delay,
                                input logic [15:0] fresh, input logic [15:0] recent);
    cfg_write(REG_STALE,  {$urandom} & 32'hFFFF_0000 | 32'(stale));
    cfg_write(REG_DELAY,  32'(delay));
    cfg_write(REG_FRESH,  32'(fresh));
    cfg_write(REG_RECENT, 32'(recent));
  endtask

  // Block until every queued frame went in and every result came back, then
  // allow for a last frame whose table emptied and so returned nothing.
  task automatic wait_idle();
    while (frame_q.size() != 0 || in_valid || track_res_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_frame(input logic [31:0] now, input logic [1:0] cnt,
                            input logic [7:0] i0, input logic signed [15:0] x0,
                            input logic signed [15:0] y0,
                            input logic [7:0] i1, input logic signed [15:0] x1,
                            input logic signed [15:0] y1,
                            input logic [7:0] i2, input logic signed [15:0] x2,
                            input logic signed [15:0] y2);
    mtt_in_t f;
    f.now_ms = now; f.det_count = cnt;
    f.det0_id = i0; f.det0_x = x0; f.det0_y = y0;
    f.det1_id = i1; f.det1_x = x1; f.det1_y = y1;
    f.det2_id = i2; f.det2_x = x2; f.det2_y = y2;
    frame_q.push_back(f);
  endtask

  function automatic logic signed [15:0] rand_mm();
    return 16'($signed($urandom_range(0, 65534)) - 32767);
  endfunction

  // Mostly a small pool of ids on a steady time base, so tracks get matched,
  // interpolated and evicted; some frames use wild ids or big time jumps.
  task automatic push_random_frames(input int n);
    logic [7:0] ids[3];
    logic [31:0] step;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 8) step = $urandom;
      else if (r < 15) step = 0;
      else step = $urandom_range(1, 150);
      t_now = t_now + step;
      for (int k = 0; k < 3; k++)
        ids[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
      push_frame(t_now, 2'($urandom),
                 ids[0], rand_mm(), rand_mm(),
                 ids[1], rand_mm(), rand_mm(),
                 ids[2], rand_mm(), rand_mm());
    end
  endtask

  initial begin
    errors      = 0;
    no_idle     = 0;
    trk_cnt     = 0;
    t_now       = 32'd1000;
    thr.stale_timeout_ms = 16'd1000;
    thr.render_lag_ms    = 10'd50;
    thr.fresh_age_ms     = 16'd200;
    thr.recent_age_ms    = 16'd500;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the reset thresholds. An empty frame on an empty
    // table, three new tracks at the extremes, then updates that interpolate.
    push_frame(32'd10, 2'd0, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    push_frame(32'd20, 2'd3, 8'd0, 16'sd32767, -16'sd32767, 8'd255, -16'sd32767,
               16'sd32767, 8'd7, 16'sd0, 16'sd0);
    push_frame(32'd40, 2'd2, 8'd0, -16'sd32767, 16'sd32767, 8'd255, 16'sd32767,
               -16'sd32767, 8'd9, 16'sd1, 16'sd1);
    push_frame(32'd120, 2'd2, 8'd0, 16'sd100, 16'sd200, 8'd255, -16'sd5, 16'sd9,
               8'd1, 16'sd0, 16'sd0);
    // Repeated id within one frame updates the same track three times.
    push_frame(32'd200, 2'd3, 8'd7, 16'sd10, 16'sd10, 8'd7, 16'sd50, -16'sd50,
               8'd7, -16'sd300, 16'sd300);
    // A fourth id on a full table evicts the least recently seen track.
    push_frame(32'd260, 2'd1, 8'd42, 16'sd3, 16'sd4, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    // New ids on a full table where all seen times tie: lowest slot goes.
    push_frame(32'd300, 2'd3, 8'd1, 16'sd1, 16'sd1, 8'd2, 16'sd2, 16'sd2,
               8'd3, 16'sd3, 16'sd3);
    push_frame(32'd300, 2'd1, 8'd4, 16'sd4, 16'sd4, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    // Ages fall into recent and old, then everything crosses the timeout.
    push_frame(32'd650, 2'd1, 8'd2, 16'sd20, 16'sd20, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    push_frame(32'd1300, 2'd0, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    push_frame(32'd1650, 2'd0, 8'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 16'sd0,
               8'd0, 16'sd0, 16'sd0);
    // Time stamps around the wrap of the 32-bit counter.
    push_frame(32'hFFFF_FFE0, 2'd2, 8'd11, 16'sd0, 16'sd0, 8'd12, 16'sd100,
               16'sd100, 8'd0, 16'sd0, 16'sd0);
    push_frame(32'hFFFF_FFFF, 2'd2, 8'd11, 16'sd500, -16'sd500, 8'd12, 16'sd0,
               16'sd0, 8'd0, 16'sd0, 16'sd0);
    push_frame(32'h0000_0040, 2'd2, 8'd11, 16'sd900, 16'sd900, 8'd12, -16'sd900,
               16'sd7, 8'd0, 16'sd0, 16'sd0);
    wait_idle();

    // Threshold extremes: longest timeout and delay, no fresh class.
    set_thresholds(16'hFFFF, 10'h3FF, 16'd0, 16'hFFFF);
    t_now = 32'd5;
    push_random_frames(40);
    wait_idle();

    // A one ms timeout and zero delay; thresholds given out of order. Here
    // the sender pauses with everything drained before each group.
    set_thresholds(16'd1, 10'd0, 16'hFFFF, 16'd0);
    no_idle = 1;
    push_random_frames(20);
    wait_idle();
    no_idle = 0;
    push_random_frames(20);
    wait_idle();

    set_thresholds(16'd300, 10'd200, 16'd500, 16'd100);
    push_random_frames(40);
    wait_idle();

    set_thresholds(16'($urandom_range(100, 65535)), 10'($urandom),
                   16'($urandom), 16'($urandom));
    push_random_frames(40);
    wait_idle();

    // Back to the reset values with the time base just below the wrap.
    set_thresholds(16'd1000, 10'd50, 16'd200, 16'd500);
    t_now = 32'hFFFF_F000;
    push_random_frames(50);
    wait_idle();

    set_thresholds(16'd2000, 10'd1000, 16'd100, 16'd1500);
    push_random_frames(50);
    wait_idle();

    if (errors == 0 && track_res_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
